// ----- hdl/grid_astar_path_search_unit_defines.svh -----
// Assertion macros used by the grid path search core
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define GAPS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid path search: assertion failed");

// next-cycle implication
`define GAPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid path search: assertion failed");

`endif

// ----- hdl/gaps_pkg.sv -----
// Types, constants and cost helpers for the grid path search unit
package gaps_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [8:0] TILE_FREE_NONE  = 9'h1FF;  // code -1
  localparam logic [8:0] TILE_FREE_FLOOR = 9'd10;

  localparam int STEP_ORTH = 10;
  localparam int STEP_DIAG = 14;

  localparam int GW = 16;  // path cost
  localparam int HW = 10;  // heuristic
  localparam int FW = 17;  // total cost

  localparam int MAX_RESULTS = 64;
  localparam int PBW         = 6;   // path buffer address bits

  localparam logic [15:0] MAX_EXP_RESET = 16'd64;

  typedef struct packed {
    logic              opcode;
    logic [2:0]        cell_x;
    logic [2:0]        cell_y;
    logic signed [8:0] tile_code;
    logic [2:0]        goal_x;
    logic [2:0]        goal_y;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic [2:0] step_x;
    logic [2:0] step_y;
    logic       last_step;
  } res_t;

  function automatic logic [5:0] absd(logic [5:0] a, logic [5:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [HW-1:0] octile(logic [5:0] dx, logic [5:0] dy);
    logic [5:0] mn;
    logic [5:0] mx;
    mn = (dx < dy) ? dx : dy;
    mx = (dx < dy) ? dy : dx;
    return HW'(STEP_DIAG * 32'(mn) + STEP_ORTH * 32'(mx - mn));
  endfunction

endpackage

// ----- hdl/grid_astar_path_search_unit.sv -----
// Top level of the grid path search unit: stream ports, register, result stage
//
// Input beats on s_*: s_tuser is the opcode (0 load a cell, 1 search). A load
// writes one cell of the obstacle map and gives no result. A search clears
// the node records, runs 8-connected A* from the start to the goal and
// returns the path, start first, on m_*, with m_tlast on the final beat;
// m_tuser low marks a single not-found beat.
// Steps of a search: clear the records, then for each expansion a full scan
// of the node memory, neighbour reads and writes and bookkeeping, then the
// trace of the path and the result beats. The node memory port sets the pace.
// One item is worked on at a time; s_tready is high only between searches.
// After reset a sweep clears the obstacle map, during which no item is
// taken. A stalled receiver holds the result stage and the search waits on
// it. max_expansions is written through cfg_we / cfg_wdata; the user must
// write it only while idle, the block itself does not enforce it.
module grid_astar_path_search_unit #(
  parameter int GRID_COLS = 8,
  parameter int GRID_ROWS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cell_x[2:0], cell_y[5:3], tile_code[14:6], goal_x[17:15], goal_y[20:18]
  input  logic [23:0] s_tdata,
  // opcode[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // step_x[2:0], step_y[5:3]
  output logic [7:0]  m_tdata,
  // found[0]
  output logic        m_tuser,
  output logic        m_tlast
);
  import gaps_pkg::*;

  logic [15:0] max_expansions;
  cmd_t        cmd;
  res_t        res;
  logic        res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_expansions <= MAX_EXP_RESET;
    end else if (cfg_we) begin
      max_expansions <= cfg_wdata;
    end
  end

  always_comb begin
    cmd.opcode    = s_tuser;
    cmd.cell_x    = s_tdata[2:0];
    cmd.cell_y    = s_tdata[5:3];
    cmd.tile_code = s_tdata[14:6];
    cmd.goal_x    = s_tdata[17:15];
    cmd.goal_y    = s_tdata[20:18];
  end

  gaps_core #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .max_expansions (max_expansions),
    .cmd_valid      (s_tvalid),
    .cmd_ready      (s_tready),
    .cmd            (cmd),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // result stage: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {2'b00, res.step_y, res.step_x};
      m_tuser <= res.found;
      m_tlast <= res.last_step;
    end
  end

endmodule

// ----- hdl/gaps_core.sv -----
// Search engine: map memory, node record memory, path buffer and sequencer
module gaps_core #(
  parameter int GRID_COLS = 8,
  parameter int GRID_ROWS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     max_expansions,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  gaps_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output gaps_pkg::res_t  res
);
  import gaps_pkg::*;
  `include "grid_astar_path_search_unit_defines.svh"

  localparam int NCELLS = GRID_COLS * GRID_ROWS;
  localparam int XW     = $clog2(GRID_COLS);
  localparam int YW     = $clog2(GRID_ROWS);
  localparam int AW     = $clog2(NCELLS);
  localparam int SW     = AW + 1;
  localparam int CW     = $clog2(NCELLS + 2);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CLR      = 4'd2;
  localparam logic [3:0] S_NB_FETCH = 4'd3;
  localparam logic [3:0] S_NB_RD    = 4'd4;
  localparam logic [3:0] S_NB_UPD   = 4'd5;
  localparam logic [3:0] S_EXP_DONE = 4'd6;
  localparam logic [3:0] S_SCAN     = 4'd7;
  localparam logic [3:0] S_CLOSE    = 4'd8;
  localparam logic [3:0] S_TR_CHK   = 4'd9;
  localparam logic [3:0] S_TR_RD    = 4'd10;
  localparam logic [3:0] S_TR_END   = 4'd11;
  localparam logic [3:0] S_OUT_RD   = 4'd12;
  localparam logic [3:0] S_OUT_LD   = 4'd13;
  localparam logic [3:0] S_NF       = 4'd14;
  localparam logic [3:0] S_NB_TAIL  = 4'd15;

  typedef struct packed {
    logic          pv;
    logic          cv;
    logic          closed;
    logic [XW-1:0] px;
    logic [YW-1:0] py;
    logic [GW-1:0] g;
    logic [HW-1:0] h;
    logic [FW-1:0] f;
  } node_t;

  function automatic logic [AW-1:0] cidx(logic [XW-1:0] x, logic [YW-1:0] y);
    return AW'(32'(y) * GRID_COLS + 32'(x));
  endfunction

  // memories
  logic        blk_mem [NCELLS];
  logic        blk_q, blk_we, blk_wd;
  logic [AW-1:0] blk_wa, blk_ra;
  node_t       node_mem [NCELLS];
  node_t       node_q, node_wd;
  logic        node_we;
  logic [AW-1:0] node_wa, node_ra;
  logic [5:0]  pb_mem [MAX_RESULTS];
  logic [5:0]  pb_q, pb_wd;
  logic        pb_we;
  logic [PBW-1:0] pb_wa, pb_ra;

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    blk_q <= blk_mem[blk_ra];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_q <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (pb_we) begin
      pb_mem[pb_wa] <= pb_wd;
    end
    pb_q <= pb_mem[pb_ra];
  end

  // control and working registers
  logic [3:0]    state;
  logic [SW-1:0] idx;
  logic [XW-1:0] sx, gx, nx, tx, sc_x, sc_dx, bx;
  logic [YW-1:0] sy, gy, ny, ty, sc_y, sc_dy, by;
  logic          same_sg, start_ph;
  logic [GW-1:0] cur_g;
  logic [15:0]   exp_cnt;
  logic [1:0]    kx, ky;
  logic          f_pend, f_out;
  logic [3:0]    f_pos;
  logic [8:0]    nbb;
  logic          sc_pend, best_ok;
  node_t         best_rec;
  logic [CW-1:0] tr_cnt;
  logic [5:0]    out_k;

  // neighbour under the (kx, ky) cursor
  logic          in_x, in_y, diag, nb_ok, nb_last, is_goal, relax_wr, take, tr_done;
  logic [XW-1:0] ncx;
  logic [YW-1:0] ncy;
  logic [AW-1:0] nidx;
  logic [3:0]    pos, pos_v, pos_h;
  logic [GW-1:0] ng;
  logic [HW-1:0] h_n, h_s;
  logic          ld_in, sr_in, ld_blk;
  logic [15:0]   cnt_n;

  always_comb begin
    in_x    = !(kx == 2'd0 && nx == '0) && !(kx == 2'd2 && nx == XW'(GRID_COLS - 1));
    in_y    = !(ky == 2'd0 && ny == '0) && !(ky == 2'd2 && ny == YW'(GRID_ROWS - 1));
    ncx     = XW'(({1'b0, nx} + (XW+1)'(kx)) - (XW+1)'(1));
    ncy     = YW'(({1'b0, ny} + (YW+1)'(ky)) - (YW+1)'(1));
    nidx    = cidx(ncx, ncy);
    pos     = 4'(3 * ky + kx);
    pos_v   = 4'(3 * ky + 1);
    pos_h   = 4'(3 + kx);
    diag    = (kx != 2'd1) && (ky != 2'd1);
    nb_last = (kx == 2'd2) && (ky == 2'd2);
    nb_ok   = in_x && in_y && !(kx == 2'd1 && ky == 2'd1) && !nbb[pos] &&
              !(diag && (nbb[pos_v] || nbb[pos_h]));
    is_goal = (ncx == gx) && (ncy == gy);
    ng      = cur_g + GW'(diag ? STEP_DIAG : STEP_ORTH);
    h_n     = octile(absd(6'(ncx), 6'(gx)), absd(6'(ncy), 6'(gy)));
    h_s     = octile(absd(6'(sx), 6'(gx)), absd(6'(sy), 6'(gy)));
    relax_wr = !(node_q.pv && node_q.g <= ng);
    take    = sc_pend && node_q.cv && !node_q.closed && !blk_q &&
              (!best_ok || node_q.f < best_rec.f ||
               (node_q.f == best_rec.f && node_q.h < best_rec.h));
    tr_done = ((tx == sx) && (ty == sy)) || (32'(tr_cnt) == NCELLS);
    ld_in   = (32'(cmd.cell_x) < GRID_COLS) && (32'(cmd.cell_y) < GRID_ROWS);
    sr_in   = ld_in && (32'(cmd.goal_x) < GRID_COLS) && (32'(cmd.goal_y) < GRID_ROWS);
    ld_blk  = !(cmd.tile_code == TILE_FREE_NONE || cmd.tile_code == TILE_FREE_FLOOR);
    cnt_n   = start_ph ? 16'd0 : exp_cnt + 16'd1;
  end

  // memory port selection
  always_comb begin
    blk_we  = 1'b0;
    blk_wa  = cidx(XW'(cmd.cell_x), YW'(cmd.cell_y));
    blk_wd  = ld_blk;
    blk_ra  = nidx;
    node_we = 1'b0;
    node_wa = nidx;
    node_wd = node_q;
    node_ra = nidx;
    pb_we   = 1'b0;
    pb_wa   = PBW'(tr_cnt);
    pb_wd   = {3'(ty), 3'(tx)};
    pb_ra   = out_k;
    case (state)
      S_INIT: begin
        blk_we = 1'b1;
        blk_wa = idx[AW-1:0];
        blk_wd = 1'b0;
      end
      S_IDLE: begin
        blk_we = cmd_valid && (cmd.opcode == OP_LOAD) && ld_in;
      end
      S_CLR: begin
        node_we = 1'b1;
        node_wa = idx[AW-1:0];
        node_wd = '0;
        if (idx[AW-1:0] == cidx(sx, sy)) begin
          node_wd.cv     = 1'b1;
          node_wd.closed = 1'b1;
          node_wd.h      = h_s;
          node_wd.f      = FW'(h_s);
        end
      end
      S_SCAN: begin
        blk_ra  = idx[AW-1:0];
        node_ra = idx[AW-1:0];
      end
      S_NB_UPD: begin
        if (!node_q.closed) begin
          node_wd.pv = 1'b1;
          node_wd.px = nx;
          node_wd.py = ny;
          if (is_goal) begin
            node_we        = 1'b1;
            node_wd.closed = 1'b1;
          end else if (relax_wr) begin
            node_we    = 1'b1;
            node_wd.cv = 1'b1;
            node_wd.g  = ng;
            node_wd.h  = h_n;
            node_wd.f  = FW'(ng) + FW'(h_n);
          end
        end
      end
      S_CLOSE: begin
        node_we        = 1'b1;
        node_wa        = cidx(bx, by);
        node_wd        = best_rec;
        node_wd.closed = 1'b1;
      end
      S_TR_CHK: begin
        node_ra = cidx(tx, ty);
        pb_we   = !tr_done && (32'(tr_cnt) < MAX_RESULTS);
      end
      S_TR_END: begin
        pb_we = 32'(tr_cnt) < MAX_RESULTS;
        pb_wd = {3'(sy), 3'(sx)};
      end
      default: begin
      end
    endcase
  end

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT_LD) || (state == S_NF);

  always_comb begin
    if (state == S_NF) begin
      res = '{found: 1'b0, step_x: 3'd0, step_y: 3'd0, last_step: 1'b1};
    end else begin
      res = '{found: 1'b1, step_x: pb_q[2:0], step_y: pb_q[5:3],
              last_step: (out_k == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      idx      <= '0;
      f_pend   <= 1'b0;
      sc_pend  <= 1'b0;
      best_ok  <= 1'b0;
      start_ph <= 1'b0;
      exp_cnt  <= '0;
      kx       <= '0;
      ky       <= '0;
      tr_cnt   <= '0;
      out_k    <= '0;
    end else begin
      case (state)
        S_INIT: begin
          idx <= idx + SW'(1);
          if (idx == SW'(NCELLS - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid && cmd.opcode == OP_SEARCH) begin
            sx       <= XW'(cmd.cell_x);
            sy       <= YW'(cmd.cell_y);
            gx       <= XW'(cmd.goal_x);
            gy       <= YW'(cmd.goal_y);
            nx       <= XW'(cmd.cell_x);
            ny       <= YW'(cmd.cell_y);
            tx       <= XW'(cmd.goal_x);
            ty       <= YW'(cmd.goal_y);
            same_sg  <= (cmd.cell_x == cmd.goal_x) && (cmd.cell_y == cmd.goal_y);
            cur_g    <= '0;
            start_ph <= 1'b1;
            tr_cnt   <= '0;
            idx      <= '0;
            kx       <= '0;
            ky       <= '0;
            f_pend   <= 1'b0;
            state    <= sr_in ? S_CLR : S_NF;
          end
        end
        S_CLR: begin
          idx <= idx + SW'(1);
          if (idx == SW'(NCELLS - 1)) begin
            state <= same_sg ? S_TR_CHK : S_NB_FETCH;
          end
        end
        S_NB_FETCH: begin
          // issue one map read per cycle, capture the one issued before
          f_pend <= 1'b1;
          f_pos  <= pos;
          f_out  <= !(in_x && in_y);
          if (f_pend) begin
            nbb[f_pos] <= f_out | blk_q;
          end
          if (kx == 2'd2) begin
            kx <= 2'd0;
            ky <= ky + 2'd1;
          end else begin
            kx <= kx + 2'd1;
          end
          if (nb_last) begin
            state <= S_NB_TAIL;
          end
        end
        S_NB_TAIL: begin
          nbb[f_pos] <= f_out | blk_q;
          f_pend     <= 1'b0;
          kx         <= '0;
          ky         <= '0;
          state      <= S_NB_RD;
        end
        S_NB_RD, S_NB_UPD: begin
          if (state == S_NB_RD && nb_ok) begin
            state <= S_NB_UPD;
          end else if (state == S_NB_UPD && !node_q.closed && is_goal) begin
            state <= S_TR_CHK;
          end else if (nb_last) begin
            state <= S_EXP_DONE;
          end else begin
            state <= S_NB_RD;
            if (kx == 2'd2) begin
              kx <= 2'd0;
              ky <= ky + 2'd1;
            end else begin
              kx <= kx + 2'd1;
            end
          end
        end
        S_EXP_DONE: begin
          exp_cnt  <= cnt_n;
          start_ph <= 1'b0;
          idx      <= '0;
          sc_x     <= '0;
          sc_y     <= '0;
          sc_pend  <= 1'b0;
          best_ok  <= 1'b0;
          state    <= (cnt_n < max_expansions) ? S_SCAN : S_NF;
        end
        S_SCAN: begin
          if (idx < SW'(NCELLS)) begin
            idx     <= idx + SW'(1);
            sc_pend <= 1'b1;
            sc_dx   <= sc_x;
            sc_dy   <= sc_y;
            if (sc_x == XW'(GRID_COLS - 1)) begin
              sc_x <= '0;
              sc_y <= sc_y + YW'(1);
            end else begin
              sc_x <= sc_x + XW'(1);
            end
          end else begin
            sc_pend <= 1'b0;
            state   <= (best_ok || take) ? S_CLOSE : S_NF;
          end
          if (take) begin
            best_ok  <= 1'b1;
            best_rec <= node_q;
            bx       <= sc_dx;
            by       <= sc_dy;
          end
        end
        S_CLOSE: begin
          nx     <= bx;
          ny     <= by;
          cur_g  <= best_rec.g;
          kx     <= '0;
          ky     <= '0;
          f_pend <= 1'b0;
          state  <= S_NB_FETCH;
        end
        S_TR_CHK: begin
          if (tr_done) begin
            state <= S_TR_END;
          end else begin
            tr_cnt <= tr_cnt + CW'(1);
            state  <= S_TR_RD;
          end
        end
        S_TR_RD: begin
          if (!node_q.pv) begin
            state <= S_TR_END;
          end else begin
            tx    <= node_q.px;
            ty    <= node_q.py;
            state <= S_TR_CHK;
          end
        end
        S_TR_END: begin
          if (32'(tr_cnt) >= MAX_RESULTS) begin
            state <= S_NF;
          end else begin
            out_k <= 6'(tr_cnt);
            state <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          if (res_ready) begin
            if (out_k == '0) begin
              state <= S_IDLE;
            end else begin
              out_k <= out_k - 6'd1;
              state <= S_OUT_RD;
            end
          end
        end
        S_NF: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GAPS_ASSERT_NEXT(a_last_to_idle, clk, rst, res_valid && res_ready && res.last_step, state == S_IDLE)
  `GAPS_ASSERT_NEXT(a_search_leaves_idle, clk, rst, cmd_valid && cmd_ready && cmd.opcode == OP_SEARCH, state != S_IDLE)
  `GAPS_ASSERT_IMP(a_trace_bound, clk, rst, state == S_TR_CHK, 32'(tr_cnt) <= NCELLS)

endmodule
